>>> rtl/yafb_pkg.sv
// Shared types and constants of the anchor box filter.
`timescale 1ns / 1ps

package yafb_pkg;

    // Default capacity of the class threshold table.
    localparam int MAX_CLASSES_DEF = 128;
    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Class counters and indexes cover a table of up to 256 entries.
    localparam int CLS_W = 8;
    // Wide enough to hold a class count of 256.
    localparam int CNT_W = CLS_W + 1;

    // Codes of the input kind field.
    localparam logic KIND_VALUE     = 1'b0;
    localparam logic KIND_THRESHOLD = 1'b1;

    // Configuration register indexes (byte address bits [3:2]).
    typedef enum logic [1:0] {
        REG_OBJ_THR     = 2'd0,
        REG_SCORE_THR   = 2'd1,
        REG_CLASS_COUNT = 2'd2,
        REG_RECORDS     = 2'd3
    } reg_idx_t;

    // Position of the next value inside an anchor record.
    typedef enum logic [2:0] {
        PH_X,
        PH_Y,
        PH_W,
        PH_H,
        PH_OBJ,
        PH_CLS
    } phase_t;

    // Operation the back end performs for one queued item.
    typedef enum logic [2:0] {
        OP_X,
        OP_Y,
        OP_W,
        OP_H,
        OP_OBJ,
        OP_CLS,
        OP_THR
    } op_t;

    typedef struct packed {
        logic        [15:0] objectness_threshold;
        logic        [15:0] score_threshold;
        logic        [7:0]  class_count;
        logic        [13:0] records_per_layer;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] value;
        logic        [6:0]  class_index;
    } in_item_t;

    typedef struct packed {
        logic        [6:0]  class_id;
        logic signed [15:0] confidence;
        logic        [14:0] left_edge;
        logic        [14:0] top_edge;
        logic signed [15:0] right_edge;
        logic signed [15:0] bottom_edge;
        logic        [13:0] record_index;
    } out_item_t;

    // One classified item travelling from front to back.
    typedef struct packed {
        op_t                op;
        logic               last;
        logic signed [15:0] value;
        logic [CLS_W-1:0]   cls;
        logic        [13:0] rec;
    } task_t;

endpackage

>>> rtl/yafb_front.sv
// Front end: accepts input transfers and tags each with its role in the record.
`timescale 1ns / 1ps

module yafb_front #(
    parameter int MAX_CLASSES = yafb_pkg::MAX_CLASSES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  yafb_pkg::cfg_t    cfg,
    input  logic              s_valid,
    input  yafb_pkg::in_item_t s_data,
    output logic              s_ready,
    input  logic              q_full,
    output logic              q_push,
    output yafb_pkg::task_t   q_data
);

    localparam int CW  = yafb_pkg::CNT_W;
    localparam int CLW = yafb_pkg::CLS_W;

    yafb_pkg::phase_t ph_reg, ph_next;
    logic [CLW-1:0]   cnt_reg, cnt_next;
    logic [13:0]      rec_reg, rec_next;

    logic             acc;
    logic [CW-1:0]    n_eff;
    logic [14:0]      rec_inc;
    logic [13:0]      rec_wrap;
    logic             cls_last;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;
    assign q_push  = acc;

    // A count above the table size acts as the table size.
    assign n_eff = (CW'(cfg.class_count) > CW'(MAX_CLASSES)) ? CW'(MAX_CLASSES)
                                                              : CW'(cfg.class_count);

    assign rec_inc  = {1'b0, rec_reg} + 15'd1;
    assign rec_wrap = (rec_inc >= {1'b0, cfg.records_per_layer}) ? 14'd0 : rec_inc[13:0];
    assign cls_last = (CW'(cnt_reg) + CW'(1)) >= n_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg  <= yafb_pkg::PH_X;
            cnt_reg <= '0;
            rec_reg <= '0;
        end else begin
            ph_reg  <= ph_next;
            cnt_reg <= cnt_next;
            rec_reg <= rec_next;
        end
    end

    always_comb begin
        ph_next      = ph_reg;
        cnt_next     = cnt_reg;
        rec_next     = rec_reg;
        q_data.op    = yafb_pkg::OP_THR;
        q_data.last  = 1'b0;
        q_data.value = s_data.value;
        q_data.cls   = CLW'(s_data.class_index);
        q_data.rec   = rec_reg;
        if (s_data.kind == yafb_pkg::KIND_VALUE) begin
            case (ph_reg)
                yafb_pkg::PH_X: begin
                    q_data.op = yafb_pkg::OP_X;
                    if (acc) ph_next = yafb_pkg::PH_Y;
                end
                yafb_pkg::PH_Y: begin
                    q_data.op = yafb_pkg::OP_Y;
                    if (acc) ph_next = yafb_pkg::PH_W;
                end
                yafb_pkg::PH_W: begin
                    q_data.op = yafb_pkg::OP_W;
                    if (acc) ph_next = yafb_pkg::PH_H;
                end
                yafb_pkg::PH_H: begin
                    q_data.op = yafb_pkg::OP_H;
                    if (acc) ph_next = yafb_pkg::PH_OBJ;
                end
                yafb_pkg::PH_OBJ: begin
                    q_data.op   = yafb_pkg::OP_OBJ;
                    q_data.last = (n_eff == '0);
                    if (acc) begin
                        if (n_eff == '0) begin
                            ph_next  = yafb_pkg::PH_X;
                            rec_next = rec_wrap;
                        end else begin
                            ph_next  = yafb_pkg::PH_CLS;
                            cnt_next = '0;
                        end
                    end
                end
                yafb_pkg::PH_CLS: begin
                    q_data.op   = yafb_pkg::OP_CLS;
                    q_data.cls  = cnt_reg;
                    q_data.last = cls_last;
                    if (acc) begin
                        if (cls_last) begin
                            ph_next  = yafb_pkg::PH_X;
                            rec_next = rec_wrap;
                        end else begin
                            cnt_next = cnt_reg + CLW'(1);
                        end
                    end
                end
                default: begin
                    ph_next = yafb_pkg::PH_X;
                end
            endcase
        end
    end

endmodule

>>> rtl/yafb_queue.sv
// Small first-in first-out queue of classified items between front and back.
`timescale 1ns / 1ps

module yafb_queue #(
    parameter int DEPTH = yafb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  yafb_pkg::task_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output yafb_pkg::task_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    yafb_pkg::task_t slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]   count_reg;

    assign full      = (count_reg == NW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) count_reg <= count_reg + NW'(1);
            else if (pop && !push) count_reg <= count_reg - NW'(1);
        end
    end

endmodule

>>> rtl/yafb_back.sv
// Back end: threshold table, score argmax and box decode with an output register.
`timescale 1ns / 1ps

module yafb_back #(
    parameter int MAX_CLASSES = yafb_pkg::MAX_CLASSES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  yafb_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  yafb_pkg::task_t    q_data,
    output logic               q_pop,
    output logic               m_valid,
    output yafb_pkg::out_item_t m_data,
    input  logic               m_ready
);

    localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CW    = yafb_pkg::CNT_W;
    localparam int CLW   = yafb_pkg::CLS_W;

    // Whole back pipeline moves together when the output register can load.
    logic adv;

    // Table access stage.
    logic signed [15:0]   thr_mem [MAX_CLASSES];
    logic [MAX_CLASSES-1:0] thr_vld_reg;
    logic [IDX_W-1:0]     addr;
    logic                 wr_en, rd_en;
    logic signed [15:0]   thr_rd_reg;
    logic                 thr_hit_reg;

    // Score stage.
    logic                 s1_valid_reg;
    yafb_pkg::task_t      s1_task_reg;
    logic signed [15:0]   cx_reg, cy_reg, bw_reg, bh_reg, obj_reg;
    logic signed [15:0]   best_score_reg, best_thr_reg;
    logic [CLW-1:0]       best_cls_reg;
    logic                 best_vld_reg;

    logic signed [31:0]   prod;
    logic signed [31:0]   psum;
    logic signed [17:0]   q18;
    logic signed [15:0]   prob;
    logic signed [15:0]   s1_thr;
    logic                 is_cls, take;
    logic signed [15:0]   new_score, new_thr;
    logic [CLW-1:0]       new_cls;
    logic                 new_vld;

    // Decision stage.
    logic                 s2_valid_reg, s2_ok_reg;
    logic [CLW-1:0]       s2_cls_reg;
    logic signed [15:0]   s2_score_reg, s2_thr_reg;
    logic [13:0]          s2_rec_reg;
    logic signed [15:0]   s2_cx_reg, s2_cy_reg, s2_bw_reg, s2_bh_reg;

    logic                 emit;
    logic signed [15:0]   hw, hh;
    logic signed [16:0]   l_sum, t_sum, r_sum, b_sum;
    logic [14:0]          l_edge, t_edge;
    logic signed [15:0]   r_edge, b_edge;

    logic                 out_valid_reg;
    yafb_pkg::out_item_t  out_data_reg;

    assign adv   = !out_valid_reg || m_ready;
    assign q_pop = adv && q_valid;

    assign addr  = q_data.cls[IDX_W-1:0];
    assign wr_en = q_pop && (q_data.op == yafb_pkg::OP_THR)
                   && (CW'(q_data.cls) < CW'(MAX_CLASSES));
    assign rd_en = q_pop && (q_data.op == yafb_pkg::OP_CLS);

    always_ff @(posedge aclk) begin
        if (wr_en) thr_mem[addr] <= q_data.value;
        if (rd_en) thr_rd_reg <= thr_mem[addr];
    end

    // An entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_vld_reg <= '0;
        end else if (wr_en) begin
            thr_vld_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) thr_hit_reg <= thr_vld_reg[addr];
        if (q_pop) s1_task_reg <= q_data;
    end

    // Score times objectness, rounded half up to Q2.14 and saturated.
    assign prod = s1_task_reg.value * obj_reg;
    assign psum = prod + 32'sd8192;
    assign q18  = psum[31:14];
    always_comb begin
        if (q18 > 18'sd32767) prob = 16'sh7fff;
        else if (q18 < -18'sd32768) prob = 16'sh8000;
        else prob = q18[15:0];
    end

    assign s1_thr    = thr_hit_reg ? thr_rd_reg : 16'sd0;
    assign is_cls    = (s1_task_reg.op == yafb_pkg::OP_CLS);
    assign take      = is_cls && (prob > best_score_reg);
    assign new_score = take ? prob : best_score_reg;
    assign new_thr   = take ? s1_thr : best_thr_reg;
    assign new_cls   = take ? s1_task_reg.cls : best_cls_reg;
    assign new_vld   = take || best_vld_reg;

    always_ff @(posedge aclk) begin
        if (adv && s1_valid_reg) begin
            case (s1_task_reg.op)
                yafb_pkg::OP_X: cx_reg <= s1_task_reg.value;
                yafb_pkg::OP_Y: cy_reg <= s1_task_reg.value;
                yafb_pkg::OP_W: bw_reg <= s1_task_reg.value;
                yafb_pkg::OP_H: bh_reg <= s1_task_reg.value;
                yafb_pkg::OP_OBJ: begin
                    obj_reg        <= s1_task_reg.value;
                    best_score_reg <= cfg.score_threshold;
                end
                yafb_pkg::OP_CLS: begin
                    best_score_reg <= new_score;
                    best_thr_reg   <= new_thr;
                    best_cls_reg   <= new_cls;
                end
                yafb_pkg::OP_THR: begin
                    // A rewrite of the leading class's threshold counts at record end.
                    if (best_vld_reg && (s1_task_reg.cls == best_cls_reg)) begin
                        best_thr_reg <= s1_task_reg.value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && is_cls && s1_task_reg.last) begin
            s2_ok_reg    <= new_vld && (obj_reg > $signed(cfg.objectness_threshold));
            s2_cls_reg   <= new_cls;
            s2_score_reg <= new_score;
            s2_thr_reg   <= new_thr;
            s2_rec_reg   <= s1_task_reg.rec;
            s2_cx_reg    <= cx_reg;
            s2_cy_reg    <= cy_reg;
            s2_bw_reg    <= bw_reg;
            s2_bh_reg    <= bh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            best_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg && is_cls && s1_task_reg.last;
            if (s1_valid_reg) begin
                if (s1_task_reg.op == yafb_pkg::OP_OBJ) best_vld_reg <= 1'b0;
                else if (is_cls) best_vld_reg <= new_vld;
            end
        end
    end

    // Box edges from centre and half size; low edges clamp at 0, high edges at 1.0.
    assign hw    = s2_bw_reg >>> 1;
    assign hh    = s2_bh_reg >>> 1;
    assign l_sum = 17'(s2_cx_reg) - 17'(hw);
    assign t_sum = 17'(s2_cy_reg) - 17'(hh);
    assign r_sum = 17'(s2_cx_reg) + 17'(hw);
    assign b_sum = 17'(s2_cy_reg) + 17'(hh);

    always_comb begin
        if (l_sum < 17'sd0) l_edge = '0;
        else if (l_sum > 17'sd32767) l_edge = 15'h7fff;
        else l_edge = l_sum[14:0];

        if (t_sum < 17'sd0) t_edge = '0;
        else if (t_sum > 17'sd32767) t_edge = 15'h7fff;
        else t_edge = t_sum[14:0];

        if (r_sum > 17'sd16384) r_edge = 16'sd16384;
        else if (r_sum < -17'sd32768) r_edge = 16'sh8000;
        else r_edge = r_sum[15:0];

        if (b_sum > 17'sd16384) b_edge = 16'sd16384;
        else if (b_sum < -17'sd32768) b_edge = 16'sh8000;
        else b_edge = b_sum[15:0];
    end

    assign emit = s2_valid_reg && s2_ok_reg && (s2_score_reg >= s2_thr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && emit) begin
            out_data_reg.class_id     <= 7'(s2_cls_reg);
            out_data_reg.confidence   <= s2_score_reg;
            out_data_reg.left_edge    <= l_edge;
            out_data_reg.top_edge     <= t_edge;
            out_data_reg.right_edge   <= r_edge;
            out_data_reg.bottom_edge  <= b_edge;
            out_data_reg.record_index <= s2_rec_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

>>> rtl/yolo_anchor_box_filter.sv
// Top level of the anchor box filter: configuration registers and the two halves.
`timescale 1ns / 1ps

// The block decodes a stream of detector values in signed Q2.14. Each anchor
// record is x, y, w, h, objectness and then class_count class scores, one value
// per transfer on the s_ channel with kind cleared. A transfer with kind set
// writes one entry of the per-class threshold table instead. After the last
// class score of a record the block sends at most one detection on the m_
// channel: winning class, score times objectness, clamped box and the record's
// position in its layer.
// Throughput is one input transfer per clock cycle, sustained, as long as no
// detection waits in the output register for a stalled receiver. The front end
// classifies each transfer and places it in a four entry queue; the back end
// pops it, reads the threshold table, multiplies and compares, and decides. A
// detection passes from the queue through the table access and decision stage
// registers into the output register that drives m_valid.
// When the receiver stalls, the result waits in the output register and the
// back end holds; the queue then absorbs further transfers until it is full,
// at which point s_ready drops.
// Synchronous reset (aresetn low) empties the pipeline, restarts the record at
// x with record index zero, makes the threshold table read as zero and loads the
// register defaults. Registers sit on the APB port at byte offsets 0, 4, 8, 12
// and should be written only while the block is idle.
module yolo_anchor_box_filter #(
    parameter int MAX_CLASSES = yafb_pkg::MAX_CLASSES_DEF,
    parameter int QUEUE_DEPTH = yafb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  yafb_pkg::in_item_t  s_data,

    output logic                m_valid,
    input  logic                m_ready,
    output yafb_pkg::out_item_t m_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    yafb_pkg::cfg_t    cfg_reg;
    yafb_pkg::reg_idx_t reg_idx;
    logic              cfg_wr;

    logic              q_full, q_push, q_pop, q_not_empty;
    yafb_pkg::task_t   q_in, q_head;

    assign pready  = 1'b1;
    assign reg_idx = yafb_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    // Register writes land on the access phase of an APB write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.objectness_threshold <= 16'd0;
            cfg_reg.score_threshold      <= 16'd0;
            cfg_reg.class_count          <= 8'd80;
            cfg_reg.records_per_layer    <= 14'd507;
        end else if (cfg_wr) begin
            case (reg_idx)
                yafb_pkg::REG_OBJ_THR:     cfg_reg.objectness_threshold <= pwdata[15:0];
                yafb_pkg::REG_SCORE_THR:   cfg_reg.score_threshold      <= pwdata[15:0];
                yafb_pkg::REG_CLASS_COUNT: cfg_reg.class_count          <= pwdata[7:0];
                yafb_pkg::REG_RECORDS:     cfg_reg.records_per_layer    <= pwdata[13:0];
                default: begin
                end
            endcase
        end
    end

    // Signed thresholds read back sign extended.
    always_comb begin
        case (reg_idx)
            yafb_pkg::REG_OBJ_THR:
                prdata = {{16{cfg_reg.objectness_threshold[15]}}, cfg_reg.objectness_threshold};
            yafb_pkg::REG_SCORE_THR:
                prdata = {{16{cfg_reg.score_threshold[15]}}, cfg_reg.score_threshold};
            yafb_pkg::REG_CLASS_COUNT:
                prdata = {24'd0, cfg_reg.class_count};
            yafb_pkg::REG_RECORDS:
                prdata = {18'd0, cfg_reg.records_per_layer};
            default:
                prdata = 32'd0;
        endcase
    end

    yafb_front #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_in)
    );

    yafb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    yafb_back #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_not_empty),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_data  (m_data),
        .m_ready (m_ready)
    );

endmodule
